>>> sv/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg: shared definitions for the node pair traffic counter
// Widths, register indexes, reset values, operation codes and the result
// record passed between the counter core and its output queue.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int NPT_NODES   = 3;
    localparam int ADDR_REGS   = 3;
    localparam int CNT_W       = 32;
    localparam int TOTAL_W     = CNT_W + 1;
    localparam int NODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROTO_W     = 8;
    localparam int PORT_W      = 16;
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDR_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDR_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDR_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_PROTOCOL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXCLUDED_PORT  = 3'd4;

    localparam logic [CNT_W-1:0]   RST_NODE_ADDR_0    = 32'hC0A8_010B;
    localparam logic [CNT_W-1:0]   RST_NODE_ADDR_1    = 32'hC0A8_010C;
    localparam logic [CNT_W-1:0]   RST_NODE_ADDR_2    = 32'hC0A8_010D;
    localparam logic [PROTO_W-1:0] RST_MATCH_PROTOCOL = 8'd6;
    localparam logic [PORT_W-1:0]  RST_EXCLUDED_PORT  = 16'd22;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [NODE_W-1:0]  lower_node;
        logic [NODE_W-1:0]  upper_node;
        logic [TOTAL_W-1:0] pair_total;
        logic               last;
    } npt_result_t;

    // Node index of an unordered pair, pairs numbered (0,1), (0,2), (1,2).
    function automatic int pair_node(input int p, input int nodes, input bit upper);
        int k;
        int r;
        k = 0;
        r = 0;
        for (int i = 0; i < nodes; i++) begin
            for (int j = i + 1; j < nodes; j++) begin
                if (k == p) begin
                    r = upper ? j : i;
                end
                k++;
            end
        end
        return r;
    endfunction

endpackage

>>> sv/node_pair_traffic_counter.sv
// ----------------------------------------------------------------------------
// node_pair_traffic_counter: per node pair packet counter
// Counts filtered packet headers between configured nodes and reports the
// two-way totals of each node pair on request, clearing them as it goes.
// ----------------------------------------------------------------------------
// The input channel carries one request per transfer: a packet header to
// classify or a report request. A header that passes the protocol and port
// filter increments the directional counters of the node pairs its addresses
// match. A report request returns one result per unordered node pair, in the
// order (0,1), (0,2), (1,2), with last set on the final one, and clears them.
// Counters are held one row per unordered pair in a two-port memory with a
// registered read; each row takes one read-modify-write slot. A header that
// hits at most one row (always so with distinct node addresses) streams at one
// per cycle while no report is pending; otherwise its rows issue one by one.
// A report's first result passes the pending mask, the read stage and the
// result queue before it is valid. A two-entry result queue lets headers keep
// flowing while the receiver stalls; report rows wait for queue space. Reset
// restores the register defaults and marks every row as zero at once. The
// configuration channel is always ready.
// ----------------------------------------------------------------------------
module node_pair_traffic_counter
    import npt_pkg::*;
#(
    parameter int NODES = NPT_NODES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [PROTO_W-1:0]     ip_protocol,
    input  logic [CNT_W-1:0]       source_address,
    input  logic [CNT_W-1:0]       dest_address,
    input  logic [PORT_W-1:0]      source_port,
    input  logic [PORT_W-1:0]      dest_port,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [NODE_W-1:0]      lower_node,
    output logic [NODE_W-1:0]      upper_node,
    output logic [TOTAL_W-1:0]     pair_total,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PAIRS = NODES * (NODES - 1) / 2;
    localparam int ROW_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ROW_BITS = 2 * CNT_W;

    logic [CNT_W-1:0]   node_addr_reg [ADDR_REGS];
    logic [PROTO_W-1:0] match_protocol_reg;
    logic [PORT_W-1:0]  excluded_port_reg;

    logic [ROW_BITS-1:0] mem [PAIRS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [PAIRS-1:0]    row_valid_reg;

    logic [PAIRS-1:0]        pend_mask_reg;
    logic [PAIRS-1:0]        pend_mask_next;
    logic [PAIRS-1:0][1:0]   pend_inc_reg;
    logic [PAIRS-1:0][1:0]   pend_inc_next;
    logic                    pend_report_reg;
    logic                    pend_report_next;

    logic [PAIRS-1:0][1:0]   new_inc;
    logic [PAIRS-1:0]        new_mask;
    logic [NODES-1:0]        src_hit;
    logic [NODES-1:0]        dst_hit;
    logic                    pass;
    logic                    in_accept;

    logic [ROW_W-1:0]        sel_row;
    logic [PAIRS-1:0]        sel_oh;
    logic                    issue;
    logic [OUT_CNT_W:0]      occ_after;

    logic                    s1_valid_reg;
    logic                    s1_report_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic [1:0]              s1_inc_reg;

    logic                    wb_valid_reg;
    logic [ROW_W-1:0]        wb_row_reg;
    logic [ROW_BITS-1:0]     wb_data_reg;

    logic [ROW_BITS-1:0]     cur_row;
    logic [CNT_W-1:0]        cnt_a;
    logic [CNT_W-1:0]        cnt_b;
    logic [ROW_BITS-1:0]     wr_data;

    npt_result_t             push_data;
    npt_result_t             out_data;
    logic                    push;
    logic [OUT_CNT_W-1:0]    fifo_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg[0]   <= RST_NODE_ADDR_0;
            node_addr_reg[1]   <= RST_NODE_ADDR_1;
            node_addr_reg[2]   <= RST_NODE_ADDR_2;
            match_protocol_reg <= RST_MATCH_PROTOCOL;
            excluded_port_reg  <= RST_EXCLUDED_PORT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NODE_ADDR_0:    node_addr_reg[0]   <= cfg_data;
                REG_NODE_ADDR_1:    node_addr_reg[1]   <= cfg_data;
                REG_NODE_ADDR_2:    node_addr_reg[2]   <= cfg_data;
                REG_MATCH_PROTOCOL: match_protocol_reg <= cfg_data[PROTO_W-1:0];
                REG_EXCLUDED_PORT:  excluded_port_reg  <= cfg_data[PORT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Classification of the incoming header.
    for (genvar n = 0; n < NODES; n++)
    begin : g_hit
        assign src_hit[n] = (node_addr_reg[n] == source_address);
        assign dst_hit[n] = (node_addr_reg[n] == dest_address);
    end

    assign pass = (ip_protocol == match_protocol_reg)
               && (source_port != excluded_port_reg)
               && (dest_port != excluded_port_reg);

    for (genvar p = 0; p < PAIRS; p++)
    begin : g_pair
        localparam int LO = pair_node(p, NODES, 1'b0);
        localparam int HI = pair_node(p, NODES, 1'b1);
        assign new_inc[p][0] = pass && src_hit[LO] && dst_hit[HI];
        assign new_inc[p][1] = pass && src_hit[HI] && dst_hit[LO];
        assign new_mask[p]   = (opcode == OP_REPORT) || (new_inc[p] != 2'b00);
    end

    // Row issue: lowest pending row first.
    always_comb
    begin
        sel_row = '0;
        sel_oh  = '0;
        for (int p = PAIRS - 1; p >= 0; p--)
        begin
            if (pend_mask_reg[p])
            begin
                sel_row = ROW_W'(p);
            end
        end
        if (pend_mask_reg != '0)
        begin
            sel_oh[sel_row] = 1'b1;
        end
    end

    assign occ_after = {1'b0, fifo_count} - {{OUT_CNT_W{1'b0}}, (out_valid && out_ready)}
                     + {{OUT_CNT_W{1'b0}}, (s1_valid_reg && s1_report_reg)};
    assign issue     = (pend_mask_reg != '0)
                    && (!pend_report_reg || (occ_after < (OUT_CNT_W + 1)'(OUT_DEPTH)));
    assign in_ready  = ((pend_mask_reg & ~(issue ? sel_oh : '0)) == '0);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        pend_mask_next   = pend_mask_reg;
        pend_inc_next    = pend_inc_reg;
        pend_report_next = pend_report_reg;
        if (issue)
        begin
            pend_mask_next = pend_mask_reg & ~sel_oh;
        end
        if (in_accept)
        begin
            pend_mask_next   = new_mask;
            pend_inc_next    = new_inc;
            pend_report_next = (opcode == OP_REPORT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg   <= '0;
            pend_report_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            wb_valid_reg    <= 1'b0;
            row_valid_reg   <= '0;
        end
        else
        begin
            pend_mask_reg   <= pend_mask_next;
            pend_report_reg <= pend_report_next;
            s1_valid_reg    <= issue;
            wb_valid_reg    <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                row_valid_reg[s1_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_inc_reg <= pend_inc_next;
        if (issue)
        begin
            s1_row_reg    <= sel_row;
            s1_report_reg <= pend_report_reg;
            s1_inc_reg    <= pend_inc_reg[sel_row];
        end
        if (s1_valid_reg)
        begin
            wb_row_reg  <= s1_row_reg;
            wb_data_reg <= wr_data;
        end
    end

    // Counter memory: one row of two directional counters per pair.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[sel_row];
        end
        if (s1_valid_reg)
        begin
            mem[s1_row_reg] <= wr_data;
        end
    end

    // A write in the cycle of the read is not seen by that read, so it is
    // forwarded from the write-back copy.
    always_comb
    begin
        priority if (wb_valid_reg && (wb_row_reg == s1_row_reg))
        begin
            cur_row = wb_data_reg;
        end
        else if (row_valid_reg[s1_row_reg])
        begin
            cur_row = rd_data_reg;
        end
        else
        begin
            cur_row = '0;
        end
    end

    assign cnt_a = cur_row[CNT_W-1:0];
    assign cnt_b = cur_row[ROW_BITS-1:CNT_W];

    always_comb
    begin
        wr_data = '0;
        if (!s1_report_reg)
        begin
            wr_data[CNT_W-1:0]        = (s1_inc_reg[0] && (cnt_a != CNT_MAX))
                                      ? cnt_a + 1'b1 : cnt_a;
            wr_data[ROW_BITS-1:CNT_W] = (s1_inc_reg[1] && (cnt_b != CNT_MAX))
                                      ? cnt_b + 1'b1 : cnt_b;
        end
    end

    assign push                 = s1_valid_reg && s1_report_reg;
    assign push_data.lower_node = NODE_W'(pair_node(int'(s1_row_reg), NODES, 1'b0));
    assign push_data.upper_node = NODE_W'(pair_node(int'(s1_row_reg), NODES, 1'b1));
    assign push_data.pair_total = {1'b0, cnt_a} + {1'b0, cnt_b};
    assign push_data.last       = (s1_row_reg == ROW_W'(PAIRS - 1));

    npt_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign lower_node = out_data.lower_node;
    assign upper_node = out_data.upper_node;
    assign pair_total = out_data.pair_total;
    assign last       = out_data.last;

endmodule

>>> sv/npt_out_fifo.sv
// ----------------------------------------------------------------------------
// npt_out_fifo: result queue
// Small queue that parts the counter pipeline from the result receiver and
// reports its fill level so that the core can reserve space for a request.
// ----------------------------------------------------------------------------
module npt_out_fifo
    import npt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  npt_result_t          push_data,
    output logic [OUT_CNT_W-1:0] count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output npt_result_t          out_data
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

    npt_result_t              entry_reg [OUT_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [OUT_CNT_W-1:0]     count_reg;
    logic [OUT_CNT_W-1:0]     count_next;
    logic                     pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/npt_checker.sv
// ----------------------------------------------------------------------------
// npt_checker: port level checks for the node pair traffic counter
// Watches the result channel for stall behaviour, pair ordering and the last flag.
// ----------------------------------------------------------------------------
module npt_checker
    import npt_pkg::*;
#(
    parameter int NODES = NPT_NODES
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [NODE_W-1:0]  lower_node,
    input logic [NODE_W-1:0]  upper_node,
    input logic [TOTAL_W-1:0] pair_total,
    input logic               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pair_total) && $stable(lower_node)
                                    && $stable(upper_node) && $stable(last))
        else $error("result changed while stalled");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lower_node < upper_node)
                      && (upper_node <= NODE_W'(NODES - 1)))
        else $error("result names an invalid node pair");

    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == ((lower_node == NODE_W'(NODES - 2))
                               && (upper_node == NODE_W'(NODES - 1)))))
        else $error("last flag does not mark the final pair");

endmodule

bind node_pair_traffic_counter npt_checker #(.NODES(NODES)) u_npt_checker (.*);
